### hdl/mtc_pkg.sv
// ----------------------------------------------------------------------------
// mtc_pkg
// shared tags, order codes and helpers for the mixed-type compare
// ----------------------------------------------------------------------------
`default_nettype none

package mtc_pkg;

    localparam logic [2:0] TAG_U32 = 3'd1;
    localparam logic [2:0] TAG_S32 = 3'd2;
    localparam logic [2:0] TAG_F32 = 3'd3;
    localparam logic [2:0] TAG_F64 = 3'd4;

    localparam logic signed [1:0] ORDER_GT = 2'sb01;
    localparam logic signed [1:0] ORDER_EQ = 2'sb00;
    localparam logic signed [1:0] ORDER_LT = 2'sb11;

    localparam logic [10:0] EXP_MAX = 11'h7ff;

    // converted operand: double bits plus invalid-tag flag
    typedef struct packed {
        logic        bad;
        logic [63:0] dbl;
    } operand_t;

    // leading zero count of a non-zero 32-bit word
    function automatic logic [4:0] lzc32(input logic [31:0] w);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (w[i])
                n = 5'(31 - i);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

### hdl/mtc_conv.sv
// ----------------------------------------------------------------------------
// mtc_conv
// turns one tagged operand into double-precision bits
// ----------------------------------------------------------------------------
`default_nettype none

module mtc_conv
    import mtc_pkg::*;
(
    input  wire logic [2:0]  tag,
    input  wire logic [63:0] bits,
    input  wire logic        to_single,
    output operand_t         opnd
);

    logic        neg;
    logic [31:0] mag;
    logic [31:0] word;
    logic [4:0]  lz;
    logic [31:0] norm;
    logic        rnd;
    logic [24:0] q;
    logic [10:0] iexp;
    logic [7:0]  fexp;
    logic [22:0] ffrac;

    assign fexp  = bits[30:23];
    assign ffrac = bits[22:0];
    assign neg   = (tag == TAG_S32) && bits[31];
    assign mag   = neg ? (32'd0 - bits[31:0]) : bits[31:0];
    assign word  = (tag == TAG_F32) ? {ffrac, 9'd0} : mag;
    assign lz    = lzc32(word);
    assign norm  = word << lz;
    // round to 24 bits, nearest even
    assign rnd   = norm[7] && ((|norm[6:0]) || norm[8]);
    assign q     = {1'b0, norm[31:8]} + {24'd0, rnd};
    assign iexp  = 11'd1054 - {6'd0, lz};

    always_comb
    begin
        opnd.bad = 1'b0;
        opnd.dbl = 64'd0;
        case (tag)
            TAG_U32, TAG_S32:
            begin
                if (mag != 32'd0)
                begin
                    if (to_single)
                    begin
                        if (q[24])
                            opnd.dbl = {neg, iexp + 11'd1, 52'd0};
                        else
                            opnd.dbl = {neg, iexp, q[22:0], 29'd0};
                    end
                    else
                    begin
                        opnd.dbl = {neg, iexp, norm[30:0], 21'd0};
                    end
                end
            end
            TAG_F32:
            begin
                if (fexp == 8'hff)
                    opnd.dbl = {bits[31], EXP_MAX, ffrac, 29'd0};
                else if (fexp != 8'd0)
                    opnd.dbl = {bits[31], {3'd0, fexp} + 11'd896, ffrac, 29'd0};
                else if (ffrac != 23'd0)
                    opnd.dbl = {bits[31], 11'd896 - {6'd0, lz}, norm[30:0], 21'd0};
                else
                    opnd.dbl = {bits[31], 63'd0};
            end
            TAG_F64:
            begin
                opnd.dbl = bits;
            end
            default:
            begin
                opnd.bad = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/mtc_cmp.sv
// ----------------------------------------------------------------------------
// mtc_cmp
// three-way compare of two converted operands
// ----------------------------------------------------------------------------
`default_nettype none

module mtc_cmp
    import mtc_pkg::*;
(
    input  operand_t                a,
    input  operand_t                b,
    output logic signed [1:0]       order
);

    logic nan_a;
    logic nan_b;
    logic zeros;
    logic mag_gt;
    logic mag_lt;

    assign nan_a  = (a.dbl[62:52] == EXP_MAX) && (a.dbl[51:0] != 52'd0);
    assign nan_b  = (b.dbl[62:52] == EXP_MAX) && (b.dbl[51:0] != 52'd0);
    assign zeros  = (a.dbl[62:0] == 63'd0) && (b.dbl[62:0] == 63'd0);
    assign mag_gt = a.dbl[62:0] > b.dbl[62:0];
    assign mag_lt = a.dbl[62:0] < b.dbl[62:0];

    always_comb
    begin
        if (a.bad || b.bad || nan_a || nan_b || zeros)
            order = ORDER_EQ;
        else if (a.dbl[63] != b.dbl[63])
            order = a.dbl[63] ? ORDER_LT : ORDER_GT;
        else if (mag_gt)
            order = a.dbl[63] ? ORDER_LT : ORDER_GT;
        else if (mag_lt)
            order = a.dbl[63] ? ORDER_GT : ORDER_LT;
        else
            order = ORDER_EQ;
    end

endmodule

`default_nettype wire

### hdl/mixed_type_three_way_compare.sv
// ----------------------------------------------------------------------------
// mixed_type_three_way_compare
// tagged number compare giving -1, 0 or 1
// ----------------------------------------------------------------------------
// A new word is taken on every cycle (busy stays low). The block is a
// three-register pipeline: input register, converted-operand register,
// result register, and the order of a word appears with done out of the
// result register. The receiver cannot stall; each result shows for one cycle.
`default_nettype none

module mixed_type_three_way_compare
    import mtc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [2:0]        first_type,
    input  wire logic [63:0]       first_value,
    input  wire logic [2:0]        second_type,
    input  wire logic [63:0]       second_value,
    output logic                   done,
    output logic signed [1:0]      order
);

    logic              in_vld_reg;
    logic              cv_vld_reg;
    logic              done_reg;
    logic [2:0]        ta_reg;
    logic [2:0]        tb_reg;
    logic [63:0]       va_reg;
    logic [63:0]       vb_reg;
    operand_t          oa_reg;
    operand_t          ob_reg;
    operand_t          oa_next;
    operand_t          ob_next;
    logic signed [1:0] order_reg;
    logic signed [1:0] order_next;
    logic              to_single;
    logic              any_sgl;
    logic              any_dbl;

    assign busy = 1'b0;

    // ints meet a single in single precision unless a double is present
    assign any_sgl   = (ta_reg == TAG_F32) || (tb_reg == TAG_F32);
    assign any_dbl   = (ta_reg == TAG_F64) || (tb_reg == TAG_F64);
    assign to_single = any_sgl && !any_dbl;

    mtc_conv u_conv_a (
        .tag       (ta_reg),
        .bits      (va_reg),
        .to_single (to_single),
        .opnd      (oa_next)
    );

    mtc_conv u_conv_b (
        .tag       (tb_reg),
        .bits      (vb_reg),
        .to_single (to_single),
        .opnd      (ob_next)
    );

    mtc_cmp u_cmp (
        .a     (oa_reg),
        .b     (ob_reg),
        .order (order_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            cv_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            in_vld_reg <= start;
            cv_vld_reg <= in_vld_reg;
            done_reg   <= cv_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ta_reg <= first_type;
            va_reg <= first_value;
            tb_reg <= second_type;
            vb_reg <= second_value;
        end
        if (in_vld_reg)
        begin
            oa_reg <= oa_next;
            ob_reg <= ob_next;
        end
        if (cv_vld_reg)
            order_reg <= order_next;
    end

    assign done  = done_reg;
    assign order = order_reg;

endmodule

`default_nettype wire
